// ===== rtl/ehc_pkg.sv =====
// ----------------------------------------------------------------------------
// ehc_pkg: shared types and constants for the header classifier
// Packet kinds, protocol numbers, fixed byte positions and the result record
// passed from the parser to the result register.
// ----------------------------------------------------------------------------
package ehc_pkg;

    // Classification codes, as seen on packet_kind
    typedef enum logic [2:0] {
        KIND_TCP      = 3'd0,
        KIND_UDP      = 3'd1,
        KIND_ICMP     = 3'd2,
        KIND_IPV4     = 3'd3,
        KIND_ARP      = 3'd4,
        KIND_OTHER    = 3'd5,
        KIND_BAD_IP   = 3'd6,
        KIND_BAD_TCP  = 3'd7
    } kind_t;

    // Ethertypes and IP protocol numbers
    localparam logic [15:0] ETYPE_IPV4     = 16'h0800;
    localparam logic [15:0] ETYPE_ARP      = 16'h0806;
    localparam logic [7:0]  PROTO_ICMP     = 8'd1;
    localparam logic [7:0]  PROTO_TCP      = 8'd6;
    localparam logic [7:0]  PROTO_UDP      = 8'd17;

    // Header sizes in bytes, and the minimum IHL in 32-bit words
    localparam logic [7:0] ETH_HDR_BYTES  = 8'd14;
    localparam logic [5:0] MIN_HDR_BYTES  = 6'd20;
    localparam logic [6:0] L4_FIXED_BYTES = 7'd8;
    localparam logic [3:0] MIN_IHL_WORDS  = 4'd5;

    // Fixed byte positions within the frame
    localparam logic [7:0] POS_ETYPE_HI = 8'd12;
    localparam logic [7:0] POS_ETYPE_LO = 8'd13;
    localparam logic [7:0] POS_IHL      = 8'd14;
    localparam logic [7:0] POS_TLEN_HI  = 8'd16;
    localparam logic [7:0] POS_TLEN_LO  = 8'd17;
    localparam logic [7:0] POS_PROTO    = 8'd23;
    localparam logic [7:0] POS_SIP_FIRST = 8'd26;
    localparam logic [7:0] POS_SIP_LAST  = 8'd29;
    localparam logic [7:0] POS_DIP_FIRST = 8'd30;
    localparam logic [7:0] POS_DIP_LAST  = 8'd33;
    localparam logic [7:0] POS_MAX       = 8'd255;

    // Offsets of transport fields from the start of the L4 header
    localparam logic [7:0] L4_SPORT_HI  = 8'd0;
    localparam logic [7:0] L4_SPORT_LO  = 8'd1;
    localparam logic [7:0] L4_DPORT_HI  = 8'd2;
    localparam logic [7:0] L4_DPORT_LO  = 8'd3;
    localparam logic [7:0] L4_TCP_DOFF  = 8'd12;

    // One classification result
    typedef struct packed {
        kind_t        kind;
        logic [31:0]  src_address;
        logic [31:0]  dst_address;
        logic [15:0]  src_port;
        logic [15:0]  dst_port;
        logic [15:0]  ip_total_length;
        logic [7:0]   payload_offset;
        logic [15:0]  payload_length;
    } result_t;

endpackage

// ===== rtl/ehc_parser.sv =====
// ----------------------------------------------------------------------------
// ehc_parser: per-frame header state and classification decision
// Tracks the byte position, captures header fields as they pass and forms
// the single result of a frame on the byte where its class is known.
// ----------------------------------------------------------------------------
module ehc_parser
(
    input  logic             clk,
    input  logic             rst_n,
    input  logic             step,
    input  logic [7:0]       octet,
    input  logic             start,
    output logic             emit,
    output ehc_pkg::result_t result
);
    import ehc_pkg::*;

    logic [7:0]  pos_reg,    pos_next,    pos_eff;
    logic        decided_reg, decided_next, decided_eff;
    logic [7:0]  etype_hi_reg, etype_hi_next, etype_hi_eff;
    logic [3:0]  ihl_reg,    ihl_next,    ihl_eff;
    logic [7:0]  proto_reg,  proto_next,  proto_eff;
    logic [15:0] tlen_reg,   tlen_next,   tlen_eff;
    logic [31:0] sip_reg,    sip_next,    sip_eff;
    logic [31:0] dip_reg,    dip_next,    dip_eff;
    logic [15:0] sport_reg,  sport_next,  sport_eff;
    logic [15:0] dport_reg,  dport_next,  dport_eff;

    logic [5:0]  hlen;
    logic [7:0]  l4_start;
    logic [5:0]  tcp_bytes;
    logic [6:0]  l4_bytes;
    logic [6:0]  hdr_sum;
    logic        with_ip;
    logic        with_ports;
    logic        zero_payload;
    kind_t       kind;
    logic [15:0] plen;
    logic [7:0]  offset;

    // A start mark clears the frame state before this byte is looked at
    always_comb
    begin
        if (start)
        begin
            pos_eff      = '0;
            decided_eff  = 1'b0;
            etype_hi_eff = '0;
            ihl_eff      = '0;
            proto_eff    = '0;
            tlen_eff     = '0;
            sip_eff      = '0;
            dip_eff      = '0;
            sport_eff    = '0;
            dport_eff    = '0;
        end
        else
        begin
            pos_eff      = pos_reg;
            decided_eff  = decided_reg;
            etype_hi_eff = etype_hi_reg;
            ihl_eff      = ihl_reg;
            proto_eff    = proto_reg;
            tlen_eff     = tlen_reg;
            sip_eff      = sip_reg;
            dip_eff      = dip_reg;
            sport_eff    = sport_reg;
            dport_eff    = dport_reg;
        end
    end

    assign hlen      = {ihl_eff, 2'b00};
    assign l4_start  = ETH_HDR_BYTES + {2'b00, hlen};
    assign tcp_bytes = {octet[7:4], 2'b00};

    // Capture fields and decide the class at its byte position
    always_comb
    begin
        pos_next      = pos_eff;
        etype_hi_next = etype_hi_eff;
        ihl_next      = ihl_eff;
        proto_next    = proto_eff;
        tlen_next     = tlen_eff;
        sip_next      = sip_eff;
        dip_next      = dip_eff;
        sport_next    = sport_eff;
        dport_next    = dport_eff;
        emit          = 1'b0;
        kind          = KIND_OTHER;
        with_ip       = 1'b0;
        with_ports    = 1'b0;
        zero_payload  = 1'b1;
        l4_bytes      = '0;

        if (!decided_eff)
        begin
            if (pos_eff != POS_MAX)
            begin
                pos_next = pos_eff + 8'd1;
            end

            if (pos_eff == POS_ETYPE_HI)
            begin
                etype_hi_next = octet;
            end
            else if (pos_eff == POS_ETYPE_LO)
            begin
                if ({etype_hi_eff, octet} == ETYPE_ARP)
                begin
                    emit = 1'b1;
                    kind = KIND_ARP;
                end
                else if ({etype_hi_eff, octet} != ETYPE_IPV4)
                begin
                    emit = 1'b1;
                    kind = KIND_OTHER;
                end
            end
            else if (pos_eff < ETH_HDR_BYTES)
            begin
                // Hold: MAC addresses are not captured
            end
            else if (pos_eff == POS_IHL)
            begin
                ihl_next = octet[3:0];
                if (octet[3:0] < MIN_IHL_WORDS)
                begin
                    emit = 1'b1;
                    kind = KIND_BAD_IP;
                end
            end
            else if (pos_eff == POS_TLEN_HI || pos_eff == POS_TLEN_LO)
            begin
                tlen_next = {tlen_eff[7:0], octet};
            end
            else if (pos_eff == POS_PROTO)
            begin
                proto_next = octet;
            end
            else if (pos_eff >= POS_SIP_FIRST && pos_eff <= POS_SIP_LAST)
            begin
                sip_next = {sip_eff[23:0], octet};
            end
            else if (pos_eff >= POS_DIP_FIRST && pos_eff <= POS_DIP_LAST)
            begin
                dip_next = {dip_eff[23:0], octet};
                if (pos_eff == POS_DIP_LAST)
                begin
                    if (proto_eff == PROTO_ICMP)
                    begin
                        emit         = 1'b1;
                        kind         = KIND_ICMP;
                        with_ip      = 1'b1;
                        zero_payload = 1'b0;
                        l4_bytes     = L4_FIXED_BYTES;
                    end
                    else if (proto_eff != PROTO_TCP && proto_eff != PROTO_UDP)
                    begin
                        emit         = 1'b1;
                        kind         = KIND_IPV4;
                        with_ip      = 1'b1;
                        zero_payload = 1'b0;
                    end
                end
            end
            else if (pos_eff == l4_start + L4_SPORT_HI || pos_eff == l4_start + L4_SPORT_LO)
            begin
                sport_next = {sport_eff[7:0], octet};
            end
            else if (pos_eff == l4_start + L4_DPORT_HI || pos_eff == l4_start + L4_DPORT_LO)
            begin
                dport_next = {dport_eff[7:0], octet};
                if (pos_eff == l4_start + L4_DPORT_LO && proto_eff == PROTO_UDP)
                begin
                    emit         = 1'b1;
                    kind         = KIND_UDP;
                    with_ip      = 1'b1;
                    with_ports   = 1'b1;
                    zero_payload = 1'b0;
                    l4_bytes     = L4_FIXED_BYTES;
                end
            end
            else if (pos_eff == l4_start + L4_TCP_DOFF && proto_eff == PROTO_TCP)
            begin
                emit       = 1'b1;
                with_ip    = 1'b1;
                with_ports = 1'b1;
                if (tcp_bytes < MIN_HDR_BYTES)
                begin
                    kind = KIND_BAD_TCP;
                end
                else
                begin
                    kind         = KIND_TCP;
                    zero_payload = 1'b0;
                    l4_bytes     = {1'b0, tcp_bytes};
                end
            end
        end
    end

    // Payload offset and saturated payload length
    assign hdr_sum = {1'b0, hlen} + l4_bytes;
    assign offset  = l4_start + {1'b0, l4_bytes};
    assign plen    = (tlen_next > {9'd0, hdr_sum}) ? (tlen_next - {9'd0, hdr_sum}) : 16'd0;

    always_comb
    begin
        result.kind            = kind;
        result.src_address     = with_ip ? sip_next : 32'd0;
        result.dst_address     = with_ip ? dip_next : 32'd0;
        result.ip_total_length = with_ip ? tlen_next : 16'd0;
        result.src_port        = with_ports ? sport_next : 16'd0;
        result.dst_port        = with_ports ? dport_next : 16'd0;
        result.payload_offset  = zero_payload ? 8'd0 : offset;
        result.payload_length  = zero_payload ? 16'd0 : plen;
    end

    assign decided_next = decided_eff | emit;

    // Advance the frame state on each processed item
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            pos_reg      <= '0;
            decided_reg  <= 1'b1;
            etype_hi_reg <= '0;
            ihl_reg      <= '0;
            proto_reg    <= '0;
            tlen_reg     <= '0;
            sip_reg      <= '0;
            dip_reg      <= '0;
            sport_reg    <= '0;
            dport_reg    <= '0;
        end
        else if (step)
        begin
            pos_reg      <= pos_next;
            decided_reg  <= decided_next;
            etype_hi_reg <= etype_hi_next;
            ihl_reg      <= ihl_next;
            proto_reg    <= proto_next;
            tlen_reg     <= tlen_next;
            sip_reg      <= sip_next;
            dip_reg      <= dip_next;
            sport_reg    <= sport_next;
            dport_reg    <= dport_next;
        end
    end

endmodule

// ===== rtl/ehc_result_reg.sv =====
// ----------------------------------------------------------------------------
// ehc_result_reg: output register of the classifier
// Holds one result item until the receiver takes it; loads a new one on
// every advance of the pipeline.
// ----------------------------------------------------------------------------
module ehc_result_reg
(
    input  logic             clk,
    input  logic             rst_n,
    input  logic             advance,
    input  logic             load_valid,
    input  ehc_pkg::result_t load_data,
    output logic             held_valid,
    output ehc_pkg::result_t held_data
);
    import ehc_pkg::*;

    logic    valid_reg;
    logic    valid_next;
    result_t data_reg;
    result_t data_next;

    // On advance the old item is gone or taken; replace it
    assign valid_next = advance ? load_valid : valid_reg;
    assign data_next  = (advance && load_valid) ? load_data : data_reg;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            valid_reg <= 1'b0;
        end
        else
        begin
            valid_reg <= valid_next;
        end
    end

    always_ff @(posedge clk)
    begin
        data_reg <= data_next;
    end

    assign held_valid = valid_reg;
    assign held_data  = data_reg;

endmodule

// ===== rtl/eth_ipv4_l4_header_classifier.sv =====
// ----------------------------------------------------------------------------
// eth_ipv4_l4_header_classifier: Ethernet / IPv4 / TCP-UDP header classifier
// Parses a byte stream of Ethernet frames and gives one class per frame.
// ----------------------------------------------------------------------------
// Usage:
//   Frame channel: frame_octet/frame_start with frame_valid and frame_stall.
//   One byte is taken per unstalled cycle; frame_start marks byte 0 of a
//   frame. Bytes outside an open frame, and after the frame's result, are
//   dropped. Result channel: packet_kind plus addresses, ports and lengths
//   with result_valid and result_stall. At most one item per frame,
//   produced on the byte where the class is known (byte 13 for non-IPv4,
//   byte 14 for a bad IP header length, byte 33 for ICMP and other IPv4,
//   the UDP destination port, or the TCP data offset byte).
//   Path: the deciding byte passes the input register and the combinational
//   parser into the result register, which then shows the result as valid.
//   Throughput: one byte per cycle while frame_stall is low; the parser
//   updates the frame state once per processed byte.
//   Stall: while a result waits under result_stall, frame_stall is raised
//   and the input register, parser state and result all hold.
//   Reset: no frame is open; the first frame_start begins parsing.
// ----------------------------------------------------------------------------
module eth_ipv4_l4_header_classifier
(
    input  logic        clk,
    input  logic        rst_n,
    input  logic        frame_valid,
    output logic        frame_stall,
    input  logic [7:0]  frame_octet,
    input  logic        frame_start,
    output logic        result_valid,
    input  logic        result_stall,
    output logic [2:0]  packet_kind,
    output logic [31:0] src_address,
    output logic [31:0] dst_address,
    output logic [15:0] src_port,
    output logic [15:0] dst_port,
    output logic [15:0] ip_total_length,
    output logic [7:0]  payload_offset,
    output logic [15:0] payload_length
);
    import ehc_pkg::*;

    logic        advance;
    logic        in_valid_reg;
    logic        in_valid_next;
    logic [7:0]  in_octet_reg;
    logic [7:0]  in_octet_next;
    logic        in_start_reg;
    logic        in_start_next;
    logic        parse_emit;
    result_t     parse_result;
    result_t     held_result;

    // Pipeline moves whenever the result register is free or being taken
    assign advance     = !(result_valid && result_stall);
    assign frame_stall = !advance;

    // Input register
    assign in_valid_next = advance ? frame_valid : in_valid_reg;
    assign in_octet_next = (advance && frame_valid) ? frame_octet : in_octet_reg;
    assign in_start_next = (advance && frame_valid) ? frame_start : in_start_reg;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            in_valid_reg <= 1'b0;
        end
        else
        begin
            in_valid_reg <= in_valid_next;
        end
    end

    always_ff @(posedge clk)
    begin
        in_octet_reg <= in_octet_next;
        in_start_reg <= in_start_next;
    end

    // Header parser
    ehc_parser u_parser
    (
        .clk    (clk),
        .rst_n  (rst_n),
        .step   (advance && in_valid_reg),
        .octet  (in_octet_reg),
        .start  (in_start_reg),
        .emit   (parse_emit),
        .result (parse_result)
    );

    // Result register
    ehc_result_reg u_result
    (
        .clk        (clk),
        .rst_n      (rst_n),
        .advance    (advance),
        .load_valid (parse_emit && in_valid_reg),
        .load_data  (parse_result),
        .held_valid (result_valid),
        .held_data  (held_result)
    );

    assign packet_kind     = held_result.kind;
    assign src_address     = held_result.src_address;
    assign dst_address     = held_result.dst_address;
    assign src_port        = held_result.src_port;
    assign dst_port        = held_result.dst_port;
    assign ip_total_length = held_result.ip_total_length;
    assign payload_offset  = held_result.payload_offset;
    assign payload_length  = held_result.payload_length;

    // Non-IP classes and bad IP headers carry no addresses or ports
    a_non_ip_zero: assert property (@(posedge clk) disable iff (!rst_n)
        result_valid && (packet_kind == KIND_ARP || packet_kind == KIND_OTHER
                         || packet_kind == KIND_BAD_IP)
        |-> src_address == 32'd0 && dst_address == 32'd0 && src_port == 16'd0
            && dst_port == 16'd0 && ip_total_length == 16'd0)
        else $error("non-IP result carries header fields");

    // A bad TCP header gives no payload position
    a_bad_tcp_payload: assert property (@(posedge clk) disable iff (!rst_n)
        result_valid && packet_kind == KIND_BAD_TCP
        |-> payload_offset == 8'd0 && payload_length == 16'd0)
        else $error("bad TCP header result has payload fields");

    // TCP payload starts past minimal Ethernet, IP and TCP headers
    a_tcp_offset: assert property (@(posedge clk) disable iff (!rst_n)
        result_valid && packet_kind == KIND_TCP |-> payload_offset >= 8'd54)
        else $error("TCP payload offset too small");

    // A stalled pipeline keeps the pending input byte
    a_input_hold: assert property (@(posedge clk) disable iff (!rst_n)
        frame_stall && in_valid_reg |=> in_valid_reg && $stable(in_octet_reg)
                                        && $stable(in_start_reg))
        else $error("input register changed under stall");

endmodule

// ===== tb/testbench.sv =====
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// testbench: frame-level test of eth_ipv4_l4_header_classifier
// Streams Ethernet frames into the classifier one byte per item, tracks the
// header fields alongside it and checks every classification it returns.
// Directed frames cover each class and the corner cases. Random frames mix
// well-formed traffic with cut, restarted and noisy streams. A long hold-off
// on the result side forces the block to stall its byte input.
// ----------------------------------------------------------------------------
module testbench;

    import ehc_pkg::*;

    localparam int RESET_CYCLES   = 7;
    localparam int LONG_HOLD      = 200;
    localparam int DRAIN_LIMIT    = 5000;
    localparam int TAIL_CYCLES    = 10;
    localparam int RANDOM_OCTETS  = 200;
    localparam int HOLD_FRAMES    = 6;

    logic        clk = 1'b0;
    logic        rst_n = 1'b0;
    logic        frame_valid = 1'b0;
    logic        frame_stall;
    logic [7:0]  frame_octet = 8'h00;
    logic        frame_start = 1'b0;
    logic        result_valid;
    logic        result_stall = 1'b0;
    logic [2:0]  packet_kind;
    logic [31:0] src_address;
    logic [31:0] dst_address;
    logic [15:0] src_port;
    logic [15:0] dst_port;
    logic [15:0] ip_total_length;
    logic [7:0]  payload_offset;
    logic [15:0] payload_length;

    eth_ipv4_l4_header_classifier dut
    (
        .clk             (clk),
        .rst_n           (rst_n),
        .frame_valid     (frame_valid),
        .frame_stall     (frame_stall),
        .frame_octet     (frame_octet),
        .frame_start     (frame_start),
        .result_valid    (result_valid),
        .result_stall    (result_stall),
        .packet_kind     (packet_kind),
        .src_address     (src_address),
        .dst_address     (dst_address),
        .src_port        (src_port),
        .dst_port        (dst_port),
        .ip_total_length (ip_total_length),
        .payload_offset  (payload_offset),
        .payload_length  (payload_length)
    );

    always
    begin
        #5 clk = 1'b1;
        #5 clk = 1'b0;
    end

    // Shadow copy of the parser state
    logic [7:0]  pos;
    logic [15:0] etype;
    logic [3:0]  ihl;
    logic [7:0]  proto;
    logic [15:0] tlen;
    logic [31:0] sip;
    logic [31:0] dip;
    logic [15:0] sport;
    logic [15:0] dport;
    bit          decided = 1'b1;

    result_t pending_classes[$];
    int      errors = 0;
    int      sent_octets = 0;
    int      burst_left = 0;
    bit      hold_req = 1'b0;

    logic [7:0] frame_buf [0:511];
    int         frame_len = 0;

    function automatic int sat_sub(input int a, input int b);
        return (a > b) ? (a - b) : 0;
    endfunction

    // Queue one classification and close the frame
    task automatic record_class(input kind_t kind, input bit with_ip, input bit with_ports,
                                input int offset, input int plen);
        result_t r;
        r.kind            = kind;
        r.src_address     = with_ip ? sip : 32'h0;
        r.dst_address     = with_ip ? dip : 32'h0;
        r.src_port        = with_ports ? sport : 16'h0;
        r.dst_port        = with_ports ? dport : 16'h0;
        r.ip_total_length = with_ip ? tlen : 16'h0;
        r.payload_offset  = offset[7:0];
        r.payload_length  = plen[15:0];
        pending_classes.push_back(r);
        decided = 1'b1;
    endtask

    // Advance the shadow parser by one accepted byte
    task automatic track_octet(input logic [7:0] octet, input logic start);
        int p;
        int hlen;
        int t;
        int tcp_bytes;
        if (start)
        begin
            pos = 8'd0; etype = 16'h0; ihl = 4'h0; proto = 8'h0; tlen = 16'h0;
            sip = 32'h0; dip = 32'h0; sport = 16'h0; dport = 16'h0;
            decided = 1'b0;
        end
        if (!decided)
        begin
            p = int'(pos);
            if (pos < 8'd255)
                pos = pos + 8'd1;
            hlen = 4 * int'(ihl);
            t = 14 + hlen;
            if (p == 12)
                etype = {octet, 8'h00};
            else if (p == 13)
            begin
                etype = etype | {8'h00, octet};
                if (etype == ETYPE_ARP)
                    record_class(KIND_ARP, 1'b0, 1'b0, 0, 0);
                else if (etype != ETYPE_IPV4)
                    record_class(KIND_OTHER, 1'b0, 1'b0, 0, 0);
            end
            else if (p < 14)
                ;
            else if (p == 14)
            begin
                ihl = octet[3:0];
                if (4 * int'(ihl) < 20)
                    record_class(KIND_BAD_IP, 1'b0, 1'b0, 0, 0);
            end
            else if (p == 16 || p == 17)
                tlen = {tlen[7:0], octet};
            else if (p == 23)
                proto = octet;
            else if (p >= 26 && p <= 29)
                sip = {sip[23:0], octet};
            else if (p >= 30 && p <= 33)
            begin
                dip = {dip[23:0], octet};
                if (p == 33)
                begin
                    if (proto == PROTO_ICMP)
                        record_class(KIND_ICMP, 1'b1, 1'b0, t + 8,
                                     sat_sub(int'(tlen), hlen + 8));
                    else if (proto != PROTO_TCP && proto != PROTO_UDP)
                        record_class(KIND_IPV4, 1'b1, 1'b0, t, sat_sub(int'(tlen), hlen));
                end
            end
            else if (p == t || p == t + 1)
                sport = {sport[7:0], octet};
            else if (p == t + 2 || p == t + 3)
            begin
                dport = {dport[7:0], octet};
                if (p == t + 3 && proto == PROTO_UDP)
                    record_class(KIND_UDP, 1'b1, 1'b1, t + 8, sat_sub(int'(tlen), hlen + 8));
            end
            else if (p == t + 12 && proto == PROTO_TCP)
            begin
                tcp_bytes = 4 * int'(octet[7:4]);
                if (tcp_bytes < 20)
                    record_class(KIND_BAD_TCP, 1'b1, 1'b1, 0, 0);
                else
                    record_class(KIND_TCP, 1'b1, 1'b1, t + tcp_bytes,
                                 sat_sub(int'(tlen), hlen + tcp_bytes));
            end
        end
    endtask

    // Offer one byte, in bursts with random gaps, and wait until it is taken
    task automatic send_octet(input logic [7:0] octet, input logic start);
        int gap;
        if (burst_left == 0)
        begin
            burst_left = $urandom_range(1, 40);
            gap = ($urandom_range(0, 3) == 0) ? 0 : $urandom_range(1, 6);
            if (gap > 0)
            begin
                frame_valid <= 1'b0;
                repeat (gap) @(posedge clk);
            end
        end
        burst_left--;
        frame_valid <= 1'b1;
        frame_octet <= octet;
        frame_start <= start;
        do
            @(posedge clk);
        while (frame_stall);
        track_octet(octet, start);
    endtask

    // Drop valid after the last item of a test
    task automatic release_sender();
        frame_valid <= 1'b0;
        @(posedge clk);
    endtask

    // Fill frame_buf with one frame; random bytes everywhere that is not a field
    task automatic build_frame(input logic [15:0] et, input logic [7:0] ver_ihl,
                               input logic [15:0] total_len, input logic [7:0] prot,
                               input logic [31:0] s_ip, input logic [31:0] d_ip,
                               input logic [15:0] s_port, input logic [15:0] d_port,
                               input logic [7:0] doff, input int tail);
        int words;
        int t;
        int i;
        words = (ver_ihl[3:0] < 4'd5) ? 5 : int'(ver_ihl[3:0]);
        t = 14 + 4 * words;
        frame_len = t + 13 + tail;
        for (i = 0; i < frame_len; i++)
            frame_buf[i] = 8'($urandom_range(0, 255));
        frame_buf[12] = et[15:8];
        frame_buf[13] = et[7:0];
        frame_buf[14] = ver_ihl;
        frame_buf[16] = total_len[15:8];
        frame_buf[17] = total_len[7:0];
        frame_buf[23] = prot;
        for (i = 0; i < 4; i++)
        begin
            frame_buf[26 + i] = s_ip[31 - 8 * i -: 8];
            frame_buf[30 + i] = d_ip[31 - 8 * i -: 8];
        end
        if (ver_ihl[3:0] >= 4'd5)
        begin
            frame_buf[t]      = s_port[15:8];
            frame_buf[t + 1]  = s_port[7:0];
            frame_buf[t + 2]  = d_port[15:8];
            frame_buf[t + 3]  = d_port[7:0];
            frame_buf[t + 12] = doff;
        end
    endtask

    // Send the first count bytes of frame_buf, marking byte 0
    task automatic send_frame(input int count);
        int i;
        for (i = 0; i < count && i < frame_len; i++)
        begin
            send_octet(frame_buf[i], i == 0);
            sent_octets++;
        end
    endtask

    function automatic logic [15:0] pick_total_length();
        return ($urandom_range(0, 1) == 0) ? 16'($urandom_range(0, 65535))
                                           : 16'($urandom_range(0, 120));
    endfunction

    function automatic logic [7:0] pick_ver_ihl();
        logic [3:0] words;
        logic [3:0] ver;
        ver = 4'($urandom_range(0, 15));
        words = ($urandom_range(0, 4) != 0) ? 4'd5 : 4'($urandom_range(5, 15));
        return {ver, words};
    endfunction

    // Result side: random stall pattern in segments, plus an on-demand long hold
    initial
    begin : result_receiver
        int seg_left;
        int stall_pct;
        int hold_left;
        seg_left = 0;
        stall_pct = 0;
        hold_left = 0;
        forever
        begin
            @(posedge clk);
            if (hold_left == 0 && hold_req)
            begin
                hold_left = LONG_HOLD;
                hold_req = 1'b0;
            end
            if (hold_left > 0)
            begin
                hold_left--;
                result_stall <= 1'b1;
            end
            else
            begin
                if (seg_left == 0)
                begin
                    seg_left = $urandom_range(5, 60);
                    case ($urandom_range(0, 4))
                        0, 1:    stall_pct = 0;
                        2:       stall_pct = 20;
                        3:       stall_pct = 50;
                        default: stall_pct = 85;
                    endcase
                end
                seg_left--;
                result_stall <= ($urandom_range(0, 99) < stall_pct);
            end
        end
    end

    function automatic void check_field(input string name, input logic [31:0] expv,
                                        input logic [31:0] actv);
        if (expv !== actv)
        begin
            $error("%s mismatch: expected 0x%0h, got 0x%0h", name, expv, actv);
            errors++;
        end
    endfunction

    // Compare each accepted classification with the oldest expectation
    always @(posedge clk)
    begin : result_checker
        result_t want;
        if (rst_n && result_valid && !result_stall)
        begin
            if (pending_classes.size() == 0)
            begin
                $error("unexpected classification, packet_kind 0x%0h", packet_kind);
                errors++;
            end
            else
            begin
                want = pending_classes.pop_front();
                check_field("packet_kind", 32'(want.kind), 32'(packet_kind));
                check_field("src_address", want.src_address, src_address);
                check_field("dst_address", want.dst_address, dst_address);
                check_field("src_port", 32'(want.src_port), 32'(src_port));
                check_field("dst_port", 32'(want.dst_port), 32'(dst_port));
                check_field("ip_total_length", 32'(want.ip_total_length),
                            32'(ip_total_length));
                check_field("payload_offset", 32'(want.payload_offset),
                            32'(payload_offset));
                check_field("payload_length", 32'(want.payload_length),
                            32'(payload_length));
            end
        end
    end

    // Each class once, field extremes and stream corner cases
    task automatic test_directed_frames();
        // idle bytes before any frame opens
        send_octet(8'h00, 1'b0);
        send_octet(8'hff, 1'b0);
        send_octet(8'h5a, 1'b0);
        send_octet(8'ha5, 1'b0);
        // non-IPv4 ethertypes
        build_frame(ETYPE_ARP, 8'h45, 16'h0054, PROTO_TCP, 32'h1, 32'h2, 16'h1, 16'h2,
                    8'h50, 0);
        send_frame(16);
        build_frame(16'hffff, 8'h45, 16'h0, 8'h0, 32'h0, 32'h0, 16'h0, 16'h0, 8'h0, 0);
        send_frame(16);
        build_frame(16'h0000, 8'h45, 16'h0, 8'h0, 32'h0, 32'h0, 16'h0, 16'h0, 8'h0, 0);
        send_frame(16);
        build_frame(16'h0801, 8'h45, 16'h0, 8'h0, 32'h0, 32'h0, 16'h0, 16'h0, 8'h0, 0);
        send_frame(16);
        // bad IP header length
        build_frame(ETYPE_IPV4, 8'h40, 16'h0, PROTO_TCP, 32'h0, 32'h0, 16'h0, 16'h0,
                    8'h50, 0);
        send_frame(16);
        build_frame(ETYPE_IPV4, 8'hf4, 16'hffff, PROTO_UDP, 32'h0, 32'h0, 16'h0, 16'h0,
                    8'h50, 0);
        send_frame(16);
        // ICMP, normal and with a length that saturates
        build_frame(ETYPE_IPV4, 8'h45, 16'h001c, PROTO_ICMP, 32'h00000000, 32'hffffffff,
                    16'h0, 16'h0, 8'h0, 2);
        send_frame(frame_len);
        build_frame(ETYPE_IPV4, 8'h45, 16'h0000, PROTO_ICMP, 32'hffffffff, 32'h00000000,
                    16'h0, 16'h0, 8'h0, 0);
        send_frame(frame_len);
        // other IPv4 protocols, version not checked
        build_frame(ETYPE_IPV4, 8'hff, 16'hffff, 8'h00, 32'hc0a80001, 32'h0a000001,
                    16'h0, 16'h0, 8'h0, 0);
        send_frame(frame_len);
        build_frame(ETYPE_IPV4, 8'h05, 16'h0010, 8'hff, 32'h01020304, 32'h05060708,
                    16'h0, 16'h0, 8'h0, 0);
        send_frame(frame_len);
        // UDP, port extremes, saturation, longest IP header
        build_frame(ETYPE_IPV4, 8'h45, 16'hffff, PROTO_UDP, 32'h7f000001, 32'hffffffff,
                    16'h0000, 16'hffff, 8'h0, 1);
        send_frame(frame_len);
        build_frame(ETYPE_IPV4, 8'h45, 16'h000a, PROTO_UDP, 32'h0, 32'h0,
                    16'hffff, 16'h0000, 8'h0, 0);
        send_frame(frame_len);
        build_frame(ETYPE_IPV4, 8'h4f, 16'h0200, PROTO_UDP, 32'haaaaaaaa, 32'h55555555,
                    16'h1234, 16'habcd, 8'h0, 0);
        send_frame(frame_len);
        // TCP, minimum and maximum data offset
        build_frame(ETYPE_IPV4, 8'h45, 16'h0028, PROTO_TCP, 32'h01010101, 32'h02020202,
                    16'd80, 16'd443, 8'h50, 3);
        send_frame(frame_len);
        build_frame(ETYPE_IPV4, 8'h4f, 16'hffff, PROTO_TCP, 32'hffffffff, 32'hffffffff,
                    16'hffff, 16'hffff, 8'hf0, 0);
        send_frame(frame_len);
        build_frame(ETYPE_IPV4, 8'h45, 16'h0000, PROTO_TCP, 32'h0, 32'h0,
                    16'h0, 16'h0, 8'h5f, 0);
        send_frame(frame_len);
        // bad TCP data offset
        build_frame(ETYPE_IPV4, 8'h45, 16'h0100, PROTO_TCP, 32'h0a0b0c0d, 32'h01020304,
                    16'd1024, 16'd22, 8'h40, 0);
        send_frame(frame_len);
        build_frame(ETYPE_IPV4, 8'h46, 16'h0100, PROTO_TCP, 32'h0, 32'h0,
                    16'h0, 16'h0, 8'h0f, 0);
        send_frame(frame_len);
        // start mark in mid-frame drops the open frame
        build_frame(ETYPE_IPV4, 8'h45, 16'h0040, PROTO_TCP, 32'h11111111, 32'h22222222,
                    16'h3333, 16'h4444, 8'h50, 0);
        send_frame(25);
        build_frame(ETYPE_IPV4, 8'h45, 16'h0040, PROTO_UDP, 32'h0, 32'h0,
                    16'h9999, 16'h8888, 8'h0, 0);
        send_frame(frame_len);
        // short frame ends one byte before its decision
        build_frame(ETYPE_IPV4, 8'h45, 16'h0040, PROTO_UDP, 32'h0, 32'h0,
                    16'h1, 16'h2, 8'h0, 0);
        send_frame(37);
        // trailing bytes after the decision are ignored
        build_frame(ETYPE_ARP, 8'h45, 16'h0, 8'h0, 32'h0, 32'h0, 16'h0, 16'h0, 8'h0, 12);
        send_frame(frame_len);
        release_sender();
    endtask

    // Mostly well-formed random traffic, with cut frames and stray bytes
    task automatic test_random_frames();
        int sel;
        int k;
        int octet_goal;
        logic [3:0] doff_hi;
        logic [3:0] doff_lo;
        logic [7:0] prot;
        octet_goal = sent_octets + RANDOM_OCTETS;
        while (sent_octets < octet_goal)
        begin
            sel = $urandom_range(0, 99);
            doff_lo = 4'($urandom_range(0, 15));
            doff_hi = ($urandom_range(0, 6) == 0) ? 4'($urandom_range(0, 4))
                                                  : 4'($urandom_range(5, 15));
            if (sel < 8)
                build_frame(ETYPE_ARP, pick_ver_ihl(), pick_total_length(), PROTO_TCP,
                            $urandom, $urandom, 16'($urandom), 16'($urandom), 8'h50, 0);
            else if (sel < 15)
                build_frame(16'($urandom_range(0, 65535)), pick_ver_ihl(),
                            pick_total_length(), PROTO_UDP, $urandom, $urandom,
                            16'($urandom), 16'($urandom), 8'h50, 0);
            else if (sel < 22)
                build_frame(ETYPE_IPV4, {4'($urandom_range(0, 15)), 4'($urandom_range(0, 4))},
                            pick_total_length(), PROTO_TCP, $urandom, $urandom,
                            16'($urandom), 16'($urandom), 8'h50, 0);
            else
            begin
                if (sel < 32)
                    prot = PROTO_ICMP;
                else if (sel < 40)
                    prot = 8'($urandom_range(0, 255));
                else if (sel < 60)
                    prot = PROTO_UDP;
                else if (sel < 85)
                    prot = PROTO_TCP;
                else
                    prot = ($urandom_range(0, 1) == 0) ? PROTO_TCP : PROTO_UDP;
                build_frame(ETYPE_IPV4, pick_ver_ihl(), pick_total_length(), prot,
                            $urandom, $urandom, 16'($urandom), 16'($urandom),
                            {doff_hi, doff_lo}, $urandom_range(0, 6));
            end
            if (sel < 85)
                send_frame(frame_len);
            else if (sel < 95)
                send_frame($urandom_range(1, frame_len - 1));
            else
            begin
                k = $urandom_range(1, 8);
                repeat (k) send_octet(8'($urandom_range(0, 255)), 1'b0);
                sent_octets += k;
            end
        end
        release_sender();
    endtask

    // Hold the result side off while short frames keep coming
    task automatic test_output_backpressure();
        int n;
        hold_req = 1'b1;
        for (n = 0; n < HOLD_FRAMES; n++)
        begin
            if (n % 3 == 2)
                build_frame(ETYPE_IPV4, 8'h45, pick_total_length(), PROTO_UDP,
                            $urandom, $urandom, 16'($urandom), 16'($urandom), 8'h0, 0);
            else
                build_frame(ETYPE_ARP, 8'h45, 16'h0, 8'h0, 32'h0, 32'h0,
                            16'h0, 16'h0, 8'h0, 0);
            send_frame(($urandom_range(0, 1) == 0) ? 14 : frame_len);
        end
        release_sender();
    endtask

    initial
    begin : main_sequence
        int waited;
        repeat (RESET_CYCLES) @(posedge clk);
        rst_n <= 1'b1;
        @(posedge clk);
        test_directed_frames();
        test_random_frames();
        test_output_backpressure();
        // drain outstanding classifications
        waited = 0;
        while (pending_classes.size() != 0 && waited < DRAIN_LIMIT)
        begin
            @(posedge clk);
            waited++;
        end
        if (pending_classes.size() != 0)
        begin
            $error("%0d classifications never arrived", pending_classes.size());
            errors++;
        end
        repeat (TAIL_CYCLES) @(posedge clk);
        if (errors == 0)
            $display("Verification passed");
        else
            $display("Verification failed");
        $finish;
    end

    initial
    begin : watchdog
        #5_000_000;
        $display("Verification failed");
        $finish;
    end

endmodule
